/* design/sxr_pkg.sv */
// Shared constants and types for the Selectrix bus receiver.
// Used by sxr_frame, sxr_store and selectrix_bus_receiver; depends on nothing.
package sxr_pkg;

	// Size of the channel store and packet length
	localparam int CHANNELS          = 112;
	localparam int FRAMES_PER_PACKET = 7;
	localparam int CH_W              = 7;
	localparam int RCH_W             = 8;

	// Receiver phase codes
	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_ADDR = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	// Framing positions and channel mapping constants
	localparam logic [2:0] SYNC_ZEROS     = 3'd3;
	localparam logic [2:0] ZERO_RUN_MAX   = 3'd7;
	localparam logic [2:0] ADDR_CLOSE_POS = 3'd7;
	localparam logic [3:0] DATA_CLOSE_POS = 4'd11;
	localparam logic [3:0] BASE_TOP       = 4'd15;
	localparam logic [2:0] FRAME_TOP      = 3'd6;

	// Channel write request from the framer to the store
	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] ch;
		logic [7:0]      val;
	} wr_req_t;

	// Per-word framer result
	typedef struct packed {
		logic       power;
		logic [1:0] phase;
		logic       done;
		wr_req_t    wr;
	} frm_res_t;

endpackage

/* design/sxr_frame.sv */
// Bit-level framer: sync search, address field and data frames.
// Holds the receiver state registers; depends on sxr_pkg.
module sxr_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,     // word leaves the input stage this cycle
	input  logic              is_bit,  // word carries a bus bit
	input  logic              bit_in,
	output sxr_pkg::frm_res_t res
);

	logic [1:0] phase_q, phase_n;
	logic [2:0] zrun_q, zrun_n;
	logic [2:0] apos_q, apos_n;
	logic [3:0] base_q, base_n;
	logic [2:0] fidx_q, fidx_n;
	logic [3:0] dpos_q, dpos_n;
	logic [7:0] shift_q, shift_n;
	logic       power_q, power_n;
	logic       done_n;
	sxr_pkg::wr_req_t wr_n;

	logic       has_bit;
	logic [2:0] bitno;
	logic [7:0] shift_base;
	logic [3:0] base_inv;
	logic [2:0] frame_inv;
	logic [sxr_pkg::CH_W-1:0] ch;
	logic [2:0] fidx_inc;

	// Map a data position to its data bit number
	always_comb begin
		has_bit = 1'b1;
		bitno   = 3'd0;
		unique case (dpos_q)
			4'd0:    bitno = 3'd0;
			4'd1:    bitno = 3'd1;
			4'd3:    bitno = 3'd2;
			4'd4:    bitno = 3'd3;
			4'd6:    bitno = 3'd4;
			4'd7:    bitno = 3'd5;
			4'd9:    bitno = 3'd6;
			4'd10:   bitno = 3'd7;
			default: has_bit = 1'b0;
		endcase
	end

	// Channel for the finished byte
	assign base_inv  = sxr_pkg::BASE_TOP - base_q;
	assign frame_inv = sxr_pkg::FRAME_TOP - fidx_q;
	assign ch        = {3'b000, base_inv} + {frame_inv, 4'b0000};
	assign fidx_inc  = fidx_q + 3'd1;
	assign shift_base = (dpos_q == 4'd0) ? 8'd0 : shift_q;

	// Next state for one bus bit
	always_comb begin
		phase_n = phase_q;
		zrun_n  = zrun_q;
		apos_n  = apos_q;
		base_n  = base_q;
		fidx_n  = fidx_q;
		dpos_n  = dpos_q;
		shift_n = shift_q;
		power_n = power_q;
		done_n  = 1'b0;
		wr_n    = '0;
		if (is_bit) begin
			unique case (phase_q)
				sxr_pkg::PH_SYNC: begin
					if (!bit_in) begin
						if (zrun_q != sxr_pkg::ZERO_RUN_MAX)
							zrun_n = zrun_q + 3'd1;
					end else if (zrun_q == sxr_pkg::SYNC_ZEROS) begin
						phase_n = sxr_pkg::PH_ADDR;
						base_n  = 4'd0;
						apos_n  = 3'd0;
					end else begin
						zrun_n = 3'd0;
					end
				end
				sxr_pkg::PH_ADDR: begin
					unique case (apos_q)
						3'd0: power_n = bit_in;
						3'd2: base_n[3] = bit_in;
						3'd3: base_n[2] = bit_in;
						3'd5: base_n[1] = bit_in;
						3'd6: base_n[0] = bit_in;
						sxr_pkg::ADDR_CLOSE_POS: begin
							phase_n = sxr_pkg::PH_DATA;
							fidx_n  = 3'd0;
							dpos_n  = 4'd0;
							shift_n = 8'd0;
						end
						default: ;
					endcase
					apos_n = apos_q + 3'd1;
				end
				sxr_pkg::PH_DATA: begin
					shift_n = shift_base;
					if (has_bit) begin
						shift_n[bitno] = bit_in;
						dpos_n = dpos_q + 4'd1;
					end else if (dpos_q == 4'd2 || dpos_q == 4'd5 || dpos_q == 4'd8) begin
						dpos_n = dpos_q + 4'd1;
					end else if (dpos_q == sxr_pkg::DATA_CLOSE_POS) begin
						if (!bit_in) begin
							// closing zero: drop the byte and resync
							phase_n = sxr_pkg::PH_SYNC;
							zrun_n  = 3'd0;
							fidx_n  = 3'd0;
							dpos_n  = 4'd0;
						end else begin
							wr_n.en  = ({1'b0, ch} < 8'(sxr_pkg::CHANNELS));
							wr_n.ch  = wr_n.en ? ch : '0;
							wr_n.val = wr_n.en ? shift_q : 8'd0;
							fidx_n   = fidx_inc;
							if (fidx_inc == 3'(sxr_pkg::FRAMES_PER_PACKET)) begin
								phase_n = sxr_pkg::PH_SYNC;
								zrun_n  = 3'd0;
								fidx_n  = 3'd0;
								dpos_n  = 4'd0;
								done_n  = 1'b1;
							end else begin
								dpos_n  = 4'd0;
								shift_n = 8'd0;
							end
						end
					end else begin
						dpos_n = 4'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the receiver state on each bus bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sxr_pkg::PH_SYNC;
			zrun_q  <= 3'd0;
			apos_q  <= 3'd0;
			base_q  <= 4'd0;
			fidx_q  <= 3'd0;
			dpos_q  <= 4'd0;
			shift_q <= 8'd0;
			power_q <= 1'b0;
		end else if (adv && is_bit) begin
			phase_q <= phase_n;
			zrun_q  <= zrun_n;
			apos_q  <= apos_n;
			base_q  <= base_n;
			fidx_q  <= fidx_n;
			dpos_q  <= dpos_n;
			shift_q <= shift_n;
			power_q <= power_n;
		end
	end

	assign res.power = power_n;
	assign res.phase = phase_n;
	assign res.done  = done_n;
	assign res.wr    = wr_n;

endmodule

/* design/sxr_store.sv */
// Channel store: byte memory with per-entry valid bits cleared at reset.
// Registered read port; depends on sxr_pkg.
module sxr_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sxr_pkg::wr_req_t           wr,
	input  logic                       rd_en,
	input  logic [sxr_pkg::RCH_W-1:0]  rd_ch,
	output logic [7:0]                 rd_data
);

	logic [7:0]                    mem [sxr_pkg::CHANNELS];
	logic [sxr_pkg::CHANNELS-1:0]  vld_q;
	logic [7:0]                    rd_data_s2;
	logic                          rd_hit_s2;
	logic                          in_range;
	logic [sxr_pkg::CH_W-1:0]      rd_idx;

	assign in_range = (rd_ch < sxr_pkg::RCH_W'(sxr_pkg::CHANNELS));
	assign rd_idx   = in_range ? rd_ch[sxr_pkg::CH_W-1:0] : '0;

	// Write the byte array
	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.ch] <= wr.val;
	end

	// Mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.ch] <= 1'b1;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_s2 <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_s2 <= 1'b0;
		end else if (rd_en) begin
			rd_hit_s2 <= in_range && vld_q[rd_idx];
		end
	end

	// Unwritten or out-of-range channels read as zero
	assign rd_data = rd_hit_s2 ? rd_data_s2 : 8'd0;

endmodule

/* design/selectrix_bus_receiver.sv */
// Selectrix bus receiver top level: input stage, framer, store and result stage.
// Depends on sxr_pkg, sxr_frame and sxr_store.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser selects the kind: 0 means
//   s_tdata[0] is a sampled bus bit, 1 means read the channel in s_tdata[8:1].
//   Every input word gives exactly one result word on m_tvalid/m_tready;
//   m_tlast flags the bit that closed the last data frame of a packet.
// Pipeline and throughput:
//   A word is registered in the input stage, processed there, and its result
//   is registered in the output stage, which drives m_tvalid. One word per
//   cycle is sustained while m_tready stays high; the framer state registers
//   and the channel memory take at most one write and one read per word.
// Reset:
//   arst_n clears the framer to sync search and marks every channel unwritten,
//   so all channels read as zero; no clearing sweep is needed.
// Stall:
//   When m_tready is low the result stays put and the input stage holds one
//   more word; s_tready drops only while both stages are full.
module selectrix_bus_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [0] data_bit, [8:1] read_channel, rest zero
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] read_data, [8] track_power, [9] wrote,
	                               // [16:10] wrote_channel, [24:17] wrote_value,
	                               // [26:25] phase, rest zero
	output logic        m_tlast    // packet_done
);

	logic                       vld_s1;
	logic                       func_s1;
	logic                       bit_s1;
	logic [sxr_pkg::RCH_W-1:0]  rch_s1;
	logic                       vld_s2;
	sxr_pkg::frm_res_t          res_s2;
	sxr_pkg::frm_res_t          frm_res;
	sxr_pkg::wr_req_t           wr_req;
	logic                       s2_free;
	logic                       adv;
	logic [7:0]                 rd_data;

	// Handshake between the two stages
	assign s2_free  = !vld_s2 || m_tready;
	assign adv      = vld_s1 && s2_free;
	assign s_tready = !vld_s1 || s2_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			bit_s1  <= s_tdata[0];
			rch_s1  <= s_tdata[8:1];
		end
	end

	// Framer
	sxr_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.is_bit (!func_s1),
		.bit_in (bit_s1),
		.res    (frm_res)
	);

	// Write only when the word actually advances
	always_comb begin
		wr_req    = frm_res.wr;
		wr_req.en = frm_res.wr.en && adv;
	end

	// Channel store
	sxr_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr_req),
		.rd_en   (adv),
		.rd_ch   (func_s1 ? rch_s1 : sxr_pkg::RCH_W'(sxr_pkg::CHANNELS)),
		.rd_data (rd_data)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= frm_res;
	end

	assign m_tvalid = vld_s2;
	assign m_tlast  = res_s2.done;
	assign m_tdata  = {5'd0, res_s2.phase, res_s2.wr.val, res_s2.wr.ch,
	                   res_s2.wr.en, res_s2.power, rd_data};

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while output stage can move");
	a_done_resyncs: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[26:25] == sxr_pkg::PH_SYNC))
		else $error("packet end not followed by sync search");
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[9]) |-> ({1'b0, m_tdata[16:10]} < 8'(sxr_pkg::CHANNELS)))
		else $error("channel write out of range");
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7:0] != 8'd0) |-> !m_tdata[9])
		else $error("read word reports a write");
`endif

endmodule
